@@ hdl/stkdm_pkg.sv @@
// stkdm_pkg: shared constants, operation and status codes, and the control
// bundle broadcast from the stack controller to every storage cell.
// no dependencies
`default_nettype none

package stkdm_pkg;

  localparam int WORD_W    = 32;
  localparam int DEPTH_DEF = 16;
  localparam int CNT_MAX_W = 11;

  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_POP  = 2'd1;
  localparam logic [1:0] FUNC_DEL  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_TOO_FEW  = 2'd2;

  typedef struct packed {
    logic                 do_push;
    logic                 do_pop;
    logic                 do_del;
    logic [CNT_MAX_W-1:0] fill;
    logic [CNT_MAX_W-1:0] pos;
  } stkdm_ctl_t;

endpackage

`default_nettype wire

@@ hdl/stkdm_cell.sv @@
// stkdm_cell: one stack entry; takes a pushed word, or the word of the cell
// above it when an entry at or below it is deleted, and taps its word out when selected.
// depends on stkdm_pkg
`default_nettype none

module stkdm_cell
  import stkdm_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire stkdm_ctl_t        ctl,
  input  wire logic [WORD_W-1:0] push_value,
  input  wire logic [WORD_W-1:0] up_data,
  output logic      [WORD_W-1:0] data,
  output logic      [WORD_W-1:0] tap
);

  localparam logic [CNT_MAX_W-1:0] MY_IDX  = CNT_MAX_W'(IDX);
  localparam logic [CNT_MAX_W-1:0] MY_NEXT = CNT_MAX_W'(IDX + 1);

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;
  logic              wr_push;
  logic              shift;
  logic              sel;

  assign wr_push = ctl.do_push && (ctl.fill == MY_IDX);
  assign shift   = ctl.do_del && (MY_IDX >= ctl.pos) && (MY_NEXT < ctl.fill);
  assign sel     = (ctl.do_pop && (MY_NEXT == ctl.fill)) ||
                   (ctl.do_del && (MY_IDX == ctl.pos));

  always_comb begin
    priority if (wr_push) begin
      data_nxt = push_value;
    end else if (shift) begin
      data_nxt = up_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign tap  = sel ? data_r : '0;

endmodule

`default_nettype wire

@@ hdl/stack_with_delete_middle.sv @@
// stack_with_delete_middle: bounded stack of signed words with push, pop and
// delete-middle, built as a row of storage cells under one fill counter.
// depends on stkdm_pkg and stkdm_cell
//
// Usage:
//   Input channel in_*: in_tuser carries the operation (push, pop, delete
//   middle), in_tdata the word to push. Every accepted item yields exactly one
//   result item on out_*: out_tdata holds the removed word (zero for push,
//   errors and the unused code) and the entry count after the operation,
//   out_tuser the status (ok, overflow, too few entries).
//   Delete-middle removes the entry at min(n/2, n-2) from the bottom; the cells
//   above it each move down one place in the same clock edge.
//   The result is registered and appears in the cycle after the item is accepted.
//   One item per cycle unless the output register stalls; every cell updates in
//   parallel from its neighbor, so the stack is never busy between items.
//   The output register holds a result until it is taken; while it is full and
//   out_tready is low, in_tready is low and no item is accepted.
//   Reset (rst_n low, synchronous) empties the stack and the output register;
//   stored words are not cleared and are never read before written.
`default_nettype none

module stack_with_delete_middle
  import stkdm_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // push_value[31:0]
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [((WORD_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] out_tdata,
                                       // value_out[31:0], entries, zero fill
  output logic [1:0]       out_tuser   // status[1:0]
);

  localparam int CW      = $clog2(DEPTH + 1);
  localparam int OUT_W   = ((WORD_W + CW + 7) / 8) * 8;
  localparam int PAD_W   = OUT_W - WORD_W - CW;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);
  localparam logic [CW-1:0] TWO  = CW'(2);

  logic [CW-1:0]     fill_r;
  logic [CW-1:0]     fill_nxt;
  logic              out_valid_r;
  logic [WORD_W-1:0] value_r;
  logic [1:0]        status_r;
  logic [1:0]        status_nxt;
  logic [CW-1:0]     entries_r;
  logic              acc;
  logic              is_push;
  logic              is_pop;
  logic              is_del;
  logic [CW-1:0]     half;
  logic [CW-1:0]     less2;
  logic [CW-1:0]     pos;
  logic [WORD_W-1:0] tap_or;
  stkdm_ctl_t        ctl;

  logic [WORD_W-1:0] cell_data [DEPTH+1];
  logic [WORD_W-1:0] cell_tap  [DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  assign is_push = acc && (in_tuser == FUNC_PUSH);
  assign is_pop  = acc && (in_tuser == FUNC_POP);
  assign is_del  = acc && (in_tuser == FUNC_DEL);

  assign half  = fill_r >> 1;
  assign less2 = fill_r - TWO;
  assign pos   = (fill_r >= TWO && half > less2) ? less2 : half;

  assign ctl.do_push = is_push && (fill_r != FULL);
  assign ctl.do_pop  = is_pop && (fill_r != '0);
  assign ctl.do_del  = is_del && (fill_r >= TWO);
  assign ctl.fill    = CNT_MAX_W'(fill_r);
  assign ctl.pos     = CNT_MAX_W'(pos);

  assign cell_data[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    stkdm_cell #(
      .IDX(i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .push_value(in_tdata),
      .up_data   (cell_data[i+1]),
      .data      (cell_data[i]),
      .tap       (cell_tap[i])
    );
  end

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  always_comb begin
    fill_nxt   = fill_r;
    status_nxt = ST_OK;
    if (ctl.do_push) begin
      fill_nxt = fill_r + CW'(1);
    end else if (ctl.do_pop || ctl.do_del) begin
      fill_nxt = fill_r - CW'(1);
    end
    if (is_push && !ctl.do_push) begin
      status_nxt = ST_OVERFLOW;
    end else if ((is_pop && !ctl.do_pop) || (is_del && !ctl.do_del)) begin
      status_nxt = ST_TOO_FEW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      value_r   <= tap_or;
      status_r  <= status_nxt;
      entries_r <= fill_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  if (PAD_W > 0) begin : g_pad
    assign out_tdata = {{PAD_W{1'b0}}, entries_r, value_r};
  end else begin : g_nopad
    assign out_tdata = {entries_r, value_r};
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("accepted item without result");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> fill_r == $past(fill_r))
    else $error("fill count moved without an item");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (is_push && fill_r == FULL) |=>
      (status_r == ST_OVERFLOW && fill_r == $past(fill_r) && value_r == '0))
    else $error("full push not reported as overflow");

endmodule

`default_nettype wire

@@ test/tb.sv @@
// tb: self-checking testbench for stack_with_delete_middle, push/pop/delete-middle
// items with random gaps and stalls on both stream sides, checked against a shadow stack
// depends on stkdm_pkg and the stack_with_delete_middle rtl
`timescale 1ns / 1ps

module tb;
  import stkdm_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int ENT_W = $clog2(DEPTH_DEF + 1);
  localparam int OUT_W = ((WORD_W + ENT_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [1:0]        status;
    logic [ENT_W-1:0]  entries;
  } stack_outcome_t;

  class stack_shadow;
    logic [WORD_W-1:0] cells [DEPTH_DEF];
    int unsigned       fill;
    stack_outcome_t    pending_results [$];
    int unsigned       errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function void note_op(logic [1:0] func, logic [WORD_W-1:0] word);
      stack_outcome_t r;
      int unsigned pos;
      r.value = '0;
      r.status = ST_OK;
      case (func)
        FUNC_PUSH: begin
          if (fill >= DEPTH_DEF) r.status = ST_OVERFLOW;
          else begin
            cells[fill] = word;
            fill++;
          end
        end
        FUNC_POP: begin
          if (fill == 0) r.status = ST_TOO_FEW;
          else begin
            fill--;
            r.value = cells[fill];
          end
        end
        FUNC_DEL: begin
          if (fill < 2) r.status = ST_TOO_FEW;
          else begin
            pos = fill / 2;
            if (pos > fill - 2) pos = fill - 2;
            r.value = cells[pos];
            for (int unsigned i = pos; i + 1 < fill; i++) cells[i] = cells[i + 1];
            fill--;
          end
        end
        default: ;
      endcase
      r.entries = ENT_W'(fill);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [WORD_W-1:0] value, logic [1:0] status,
                               logic [ENT_W-1:0] entries);
      stack_outcome_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item: value %h status %0d entries %0d",
                 $time, value, status, entries);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (value !== want.value) begin
        $display("%0t: value_out expected %h actual %h", $time, want.value, value);
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        errors++;
      end
      if (entries !== want.entries) begin
        $display("%0t: entries expected %0d actual %0d", $time, want.entries, entries);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;   // push_value[31:0]
  logic [1:0]        in_tuser = '0;   // func[1:0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;       // value_out[31:0], entries, zero fill
  logic [1:0]        out_tuser;       // status[1:0]

  stack_shadow shadow = new();
  bit          sender_burst = 1'b0;
  bit          receiver_burst = 1'b0;
  int unsigned cycles = 0;

  stack_with_delete_middle u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      shadow.check_result(out_tdata[WORD_W-1:0], out_tuser, out_tdata[WORD_W +: ENT_W]);
  end

  task automatic send_item(input logic [1:0] func, input logic [31:0] word);
    int gap;
    if ($urandom_range(0, 31) == 0) sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.note_op(func, word);
  endtask

  // result side stalls
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) receiver_burst = !receiver_burst;
      stall = receiver_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    int          mode;
    int          seg_left;
    int          roll;
    logic [1:0]  func;
    logic [31:0] word;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stack, single entry, two entries
    send_item(FUNC_POP, 32'h0);
    send_item(FUNC_DEL, 32'h0);
    send_item(FUNC_UNUSED, 32'hFFFF_FFFF);
    send_item(FUNC_PUSH, 32'h7FFF_FFFF);
    send_item(FUNC_DEL, 32'h0);
    send_item(FUNC_POP, 32'h0);
    send_item(FUNC_PUSH, 32'h8000_0000);
    send_item(FUNC_PUSH, 32'hFFFF_FFFF);
    send_item(FUNC_DEL, 32'h0);
    send_item(FUNC_POP, 32'h0);
    // fill up, then overflow and removal on a full stack
    for (int i = 0; i < DEPTH_DEF; i++)
      send_item(FUNC_PUSH, (i % 2) ? 32'hAAAA_AAAA ^ i : 32'h5555_5555 ^ i);
    send_item(FUNC_PUSH, 32'h1234_5678);
    send_item(FUNC_UNUSED, 32'h0);
    send_item(FUNC_DEL, 32'h0);

    // phases that drift toward full, toward empty, or stay balanced
    mode = 0;
    seg_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        mode = $urandom_range(0, 2);
        seg_left = $urandom_range(5, 40);
      end
      seg_left--;
      roll = $urandom_range(0, 99);
      case (mode)
        0: func = (roll < 75) ? FUNC_PUSH : (roll < 85) ? FUNC_POP :
                  (roll < 97) ? FUNC_DEL : FUNC_UNUSED;
        1: func = (roll < 25) ? FUNC_PUSH : (roll < 60) ? FUNC_POP :
                  (roll < 97) ? FUNC_DEL : FUNC_UNUSED;
        default: func = (roll < 48) ? FUNC_PUSH : (roll < 72) ? FUNC_POP :
                        (roll < 97) ? FUNC_DEL : FUNC_UNUSED;
      endcase
      case ($urandom_range(0, 15))
        0: word = 32'h0;
        1: word = 32'hFFFF_FFFF;
        2: word = 32'h8000_0000;
        3: word = 32'h7FFF_FFFF;
        default: word = $urandom;
      endcase
      send_item(func, word);
    end
    in_tvalid <= 1'b0;

    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/stkdm_pkg.sv
hdl/stkdm_cell.sv
hdl/stack_with_delete_middle.sv
test/tb.sv
